// ===== rtl/core/trpd_pkg.sv =====
package trpd_pkg;

  // Input word: one byte read from the touch controller.
  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_word_t;

  // Result word: one decoded point, or an empty marker that ends a read.
  typedef struct packed {
    logic        has_point;
    logic [2:0]  point_index;
    logic [2:0]  point_count;
    logic [11:0] x_position;
    logic [11:0] y_position;
    logic        last;
  } out_word_t;

  // Byte kinds carried in the op field.
  localparam logic OP_FLAG   = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // Configuration register indexes.
  localparam logic REG_PANEL_LIMIT = 1'b0;
  localparam logic REG_CLIENT_CAP  = 1'b1;

  // Report layout and limits.
  localparam logic [3:0] POINT_ID         = 4'h6;
  localparam logic [2:0] MAX_TOUCH_POINTS = 3'd5;
  localparam int         NUM_POINTS       = 5;
  localparam logic [4:0] REPORT_BYTES     = 5'd27;
  localparam logic [4:0] POS_MAX          = 5'd31;
  localparam logic [2:0] LIMIT_RESET      = 3'd5;

  // Offset of a point's record within the report; its bytes sit at base+1..base+3.
  function automatic logic [4:0] point_base(input logic [2:0] idx);
    logic [4:0] base;
    unique case (idx)
      3'd0:    base = 5'd0;
      3'd1:    base = 5'd7;
      3'd2:    base = 5'd12;
      3'd3:    base = 5'd17;
      3'd4:    base = 5'd22;
      default: base = 5'd31;
    endcase
    return base;
  endfunction

endpackage

// ===== rtl/core/trpd_in_stage.sv =====
module trpd_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  trpd_pkg::in_word_t in_word,
  input  logic               s1_take,
  output logic               s1_valid,
  output trpd_pkg::in_word_t s1_word
);

  logic               s1_valid_r;
  logic               s1_valid_nxt;
  trpd_pkg::in_word_t s1_word_r;
  logic               in_fire;

  // The stage takes a new word when empty or when its word moves on this cycle.
  assign in_ready = !s1_valid_r || s1_take;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_r <= in_word;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_word  = s1_word_r;

endmodule

// ===== rtl/core/trpd_parser.sv =====
module trpd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          panel_point_limit,
  input  logic [2:0]          client_capacity,
  input  logic                s1_valid,
  input  trpd_pkg::in_word_t  s1_word,
  output logic                s1_take,
  output logic                out_valid,
  input  logic                out_ready,
  output trpd_pkg::out_word_t out_word
);

  logic [4:0]          pos_r, pos_nxt;
  logic [2:0]          ptd_r, ptd_nxt;
  logic                active_r, active_nxt;
  logic [7:0]          xh_r, xh_nxt;
  logic [7:0]          yh_r, yh_nxt;
  logic                out_valid_r, out_valid_nxt;
  trpd_pkg::out_word_t out_word_r;
  trpd_pkg::out_word_t res;
  logic                emit;
  logic [2:0]          clamp_cnt;
  logic                hit_x, hit_y, hit_pt;
  logic [2:0]          pt_idx;
  logic [3:0]          nib_lo;
  logic [4:0]          base;

  // A word is processed whenever the result register can take its outcome.
  assign s1_take = s1_valid && (!out_valid_r || out_ready);
  assign nib_lo  = s1_word.data_byte[3:0];

  // Reported count clamped to the panel limit, client capacity and point maximum.
  always_comb begin
    logic [3:0] n;
    n = nib_lo;
    if (n > {1'b0, panel_point_limit}) n = {1'b0, panel_point_limit};
    if (n > {1'b0, client_capacity}) n = {1'b0, client_capacity};
    if (n > {1'b0, trpd_pkg::MAX_TOUCH_POINTS}) n = {1'b0, trpd_pkg::MAX_TOUCH_POINTS};
    clamp_cnt = n[2:0];
  end

  // Match the current byte offset against the records of the points in play.
  always_comb begin
    hit_x  = 1'b0;
    hit_y  = 1'b0;
    hit_pt = 1'b0;
    pt_idx = 3'd0;
    base   = 5'd0;
    for (int i = 0; i < trpd_pkg::NUM_POINTS; i++) begin
      base = trpd_pkg::point_base(3'(i));
      if (3'(i) < ptd_r) begin
        if (pos_r == base + 5'd1) begin
          hit_x  = 1'b1;
          pt_idx = 3'(i);
        end
        if (pos_r == base + 5'd2) begin
          hit_y  = 1'b1;
          pt_idx = 3'(i);
        end
        if (pos_r == base + 5'd3) begin
          hit_pt = 1'b1;
          pt_idx = 3'(i);
        end
      end
    end
  end

  // Per-byte state update and result build.
  always_comb begin
    pos_nxt    = pos_r;
    ptd_nxt    = ptd_r;
    active_nxt = active_r;
    xh_nxt     = xh_r;
    yh_nxt     = yh_r;
    emit       = 1'b0;
    res        = '0;
    res.last   = 1'b1;
    if (s1_take) begin
      if (s1_word.op == trpd_pkg::OP_FLAG) begin
        pos_nxt = 5'd0;
        if (nib_lo == 4'd0) begin
          emit       = 1'b1;
          active_nxt = 1'b0;
        end else begin
          ptd_nxt    = clamp_cnt;
          active_nxt = 1'b1;
        end
      end else if (active_r) begin
        if (pos_r != trpd_pkg::POS_MAX) begin
          pos_nxt = pos_r + 5'd1;
        end
        priority if (pos_r >= trpd_pkg::REPORT_BYTES) begin
          active_nxt = 1'b0;
        end else if (pos_r == 5'd0) begin
          // Unsettled report or nothing to deliver: one empty result.
          if (nib_lo != trpd_pkg::POINT_ID || ptd_r == 3'd0) begin
            emit       = 1'b1;
            active_nxt = 1'b0;
          end
        end else if (hit_x) begin
          xh_nxt = s1_word.data_byte;
        end else if (hit_y) begin
          yh_nxt = s1_word.data_byte;
        end else if (hit_pt) begin
          emit            = 1'b1;
          res.has_point   = 1'b1;
          res.point_index = pt_idx;
          res.point_count = ptd_r;
          res.x_position  = {xh_r, s1_word.data_byte[7:4]};
          res.y_position  = {yh_r, s1_word.data_byte[3:0]};
          res.last        = (pt_idx + 3'd1 == ptd_r);
          if (pt_idx + 3'd1 == ptd_r) begin
            active_nxt = 1'b0;
          end
        end
      end
    end
  end

  // Result register: cleared when taken, loaded when a word yields a result.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 5'd0;
      ptd_r       <= 3'd0;
      active_r    <= 1'b0;
      xh_r        <= 8'd0;
      yh_r        <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      ptd_r       <= ptd_nxt;
      active_r    <= active_nxt;
      xh_r        <= xh_nxt;
      yh_r        <= yh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== rtl/core/touch_report_point_decoder.sv =====
// Touch report point decoder.
// Input channel (in_valid/in_ready/in_word): one controller byte per word. A word
// with op clear is the flag byte that opens a read; words with op set are the
// report bytes that follow it.
// Result channel (out_valid/out_ready/out_word): at most one result per input
// word, either a decoded point or an empty word that ends a read with no touch
// or an unsettled report. The last field marks the final result of a read.
// Configuration port (cfg_wr_en/cfg_index/cfg_wdata): panel point limit at index
// zero, client capacity at index one; write only while the block is idle.
// A byte is captured in the input register at acceptance, parsed combinationally,
// and its result is loaded into the result register when the parser takes it.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// combinational parse between those two registers.
// Reset clears the parse state and both pipeline registers and sets both limits
// to five. When the receiver stalls, the result is held in its register and no
// byte leaves the input register, so in_ready drops as soon as that register is
// full; at most one byte waits behind a stalled result.
module touch_report_point_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  trpd_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output trpd_pkg::out_word_t out_word,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [2:0]          cfg_wdata
);

  logic [2:0]         panel_lim_r, panel_lim_nxt;
  logic [2:0]         client_cap_r, client_cap_nxt;
  logic               s1_valid;
  logic               s1_take;
  trpd_pkg::in_word_t s1_word;

  // Configuration registers.
  always_comb begin
    panel_lim_nxt  = panel_lim_r;
    client_cap_nxt = client_cap_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        trpd_pkg::REG_PANEL_LIMIT: panel_lim_nxt  = cfg_wdata;
        trpd_pkg::REG_CLIENT_CAP:  client_cap_nxt = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_lim_r  <= trpd_pkg::LIMIT_RESET;
      client_cap_r <= trpd_pkg::LIMIT_RESET;
    end else begin
      panel_lim_r  <= panel_lim_nxt;
      client_cap_r <= client_cap_nxt;
    end
  end

  // Input register.
  trpd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .s1_take  (s1_take),
    .s1_valid (s1_valid),
    .s1_word  (s1_word)
  );

  // Report parser and result register.
  trpd_parser u_parser (
    .clk               (clk),
    .rst_n             (rst_n),
    .panel_point_limit (panel_lim_r),
    .client_capacity   (client_cap_r),
    .s1_valid          (s1_valid),
    .s1_word           (s1_word),
    .s1_take           (s1_take),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_word          (out_word)
  );

endmodule

// ===== rtl/core/trpd_checker.sv =====
module trpd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input trpd_pkg::out_word_t out_word
);

  // A stalled result holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result changed while stalled");

  // An empty result carries no coordinates and always ends the read.
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.has_point |->
      out_word.last && out_word.point_index == 3'd0 && out_word.point_count == 3'd0 &&
      out_word.x_position == 12'd0 && out_word.y_position == 12'd0)
    else $error("empty result is malformed");

  // A point lies within its report's count, which never exceeds five.
  a_point_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.has_point |->
      out_word.point_index < out_word.point_count && out_word.point_count <= 3'd5)
    else $error("point index or count out of range");

  // Only the final point of a report is marked last.
  a_point_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.has_point |->
      out_word.last == (3'(out_word.point_index + 3'd1) == out_word.point_count))
    else $error("last flag does not match point position");

endmodule

bind touch_report_point_decoder trpd_checker u_trpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

// ===== tb/sv/touch_point_checker.sv =====
`timescale 1ns / 100ps

// Watches the byte channel, the result channel and the limit writes of the
// touch report point decoder, predicts every result word and compares.
module touch_point_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  trpd_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  logic                out_ready,
  input  trpd_pkg::out_word_t out_word,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [2:0]          cfg_wdata,
  output int                  mismatch_count,
  output int                  points_pending
);

  // Mirror of the decoder's limits and parse state.
  logic [2:0] panel_limit;
  logic [2:0] client_cap;
  logic [4:0] next_pos;
  logic [2:0] point_total;
  logic       in_report;
  logic [7:0] x_high;
  logic [7:0] y_high;

  trpd_pkg::out_word_t expected_points[$];
  int                  errors;

  // Works out the result word, if any, that one accepted byte causes.
  function automatic void decode_byte(input trpd_pkg::in_word_t w);
    logic [3:0]          count;
    logic [4:0]          pos;
    logic [4:0]          base;
    trpd_pkg::out_word_t res;
    int                  i;
    res = '0;
    res.last = 1'b1;
    if (w.op == trpd_pkg::OP_FLAG) begin
      count = w.data_byte[3:0];
      next_pos = '0;
      if (count == 4'd0) begin
        in_report = 1'b0;
        expected_points.push_back(res);
        return;
      end
      if (count > {1'b0, panel_limit}) count = {1'b0, panel_limit};
      if (count > {1'b0, client_cap}) count = {1'b0, client_cap};
      if (count > {1'b0, trpd_pkg::MAX_TOUCH_POINTS}) begin
        count = {1'b0, trpd_pkg::MAX_TOUCH_POINTS};
      end
      point_total = count[2:0];
      in_report = 1'b1;
      return;
    end
    if (!in_report) return;
    pos = next_pos;
    if (next_pos < trpd_pkg::POS_MAX) next_pos = next_pos + 5'd1;
    if (pos >= trpd_pkg::REPORT_BYTES) begin
      in_report = 1'b0;
      return;
    end
    // The first report byte carries the identifier; a bad one or an empty
    // count ends the read with an empty word.
    if (pos == 5'd0) begin
      if (w.data_byte[3:0] != trpd_pkg::POINT_ID || point_total == 3'd0) begin
        in_report = 1'b0;
        expected_points.push_back(res);
      end
      return;
    end
    for (i = 0; i < int'(point_total) && i < trpd_pkg::NUM_POINTS; i++) begin
      base = (i == 0) ? 5'd0 : 5'(i * 5 + 2);
      if (pos == base + 5'd1) begin
        x_high = w.data_byte;
        return;
      end
      if (pos == base + 5'd2) begin
        y_high = w.data_byte;
        return;
      end
      if (pos == base + 5'd3) begin
        res.has_point   = 1'b1;
        res.point_index = 3'(i);
        res.point_count = point_total;
        res.x_position  = {x_high, w.data_byte[7:4]};
        res.y_position  = {y_high, w.data_byte[3:0]};
        res.last        = (3'(i + 1) == point_total);
        if (res.last) in_report = 1'b0;
        expected_points.push_back(res);
        return;
      end
    end
  endfunction

  // Reports one field that differs and returns 1 when it does.
  function automatic int field_differs(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Everything is sampled at the rising edge, after the stimulus settled.
  always @(posedge clk) begin
    trpd_pkg::out_word_t want;
    int                  bad;
    if (!rst_n) begin
      panel_limit = trpd_pkg::LIMIT_RESET;
      client_cap  = trpd_pkg::LIMIT_RESET;
      next_pos    = '0;
      point_total = '0;
      in_report   = 1'b0;
      x_high      = '0;
      y_high      = '0;
      expected_points.delete();
      errors      = 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == trpd_pkg::REG_PANEL_LIMIT) panel_limit = cfg_wdata;
        else client_cap = cfg_wdata;
      end
      if (in_valid && in_ready) decode_byte(in_word);
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          $error("result word arrived with no expected result pending");
          errors++;
        end else begin
          want = expected_points.pop_front();
          bad = 0;
          bad += field_differs("has_point", int'(want.has_point),
                               int'(out_word.has_point));
          bad += field_differs("point_index", int'(want.point_index),
                               int'(out_word.point_index));
          bad += field_differs("point_count", int'(want.point_count),
                               int'(out_word.point_count));
          bad += field_differs("x_position", int'(want.x_position),
                               int'(out_word.x_position));
          bad += field_differs("y_position", int'(want.y_position),
                               int'(out_word.y_position));
          bad += field_differs("last", int'(want.last), int'(out_word.last));
          if (bad != 0) errors++;
        end
      end
    end
    mismatch_count <= errors;
    points_pending <= expected_points.size();
  end

endmodule

// ===== tb/sv/tb_touch_report_point_decoder.sv =====
`timescale 1ns / 100ps

module tb_touch_report_point_decoder;

  localparam int ITEM_TARGET = 2000;
  localparam int NUM_PHASES  = 9;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 8;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  trpd_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_ready;
  trpd_pkg::out_word_t out_word;
  logic                cfg_wr_en;
  logic                cfg_index;
  logic [2:0]          cfg_wdata;

  int         mismatch_count;
  int         points_pending;
  int         cycles;
  int         bytes_sent;
  logic       steady_tail;
  logic [2:0] cur_panel;
  logic [2:0] cur_client;

  // Limit settings per phase; the last phase keeps both sides busy.
  logic [2:0] phase_panel[NUM_PHASES]  = '{3'd0, 3'd5, 3'd7, 3'd1, 3'd5, 3'd6, 3'd3, 3'd2, 3'd5};
  logic [2:0] phase_client[NUM_PHASES] = '{3'd5, 3'd0, 3'd7, 3'd5, 3'd1, 3'd2, 3'd4, 3'd7, 3'd5};

  touch_report_point_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  touch_point_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_word       (out_word),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .points_pending (points_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop in case the block hangs or drops results.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver side: random stall bursts, none during the steady tail.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!steady_tail && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Offers one word, with an optional gap first, and waits until it is taken.
  task automatic send_word(input logic op, input logic [7:0] data);
    trpd_pkg::in_word_t w;
    w.op = op;
    w.data_byte = data;
    @(negedge clk);
    if (!steady_tail && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Stops sending and waits until every expected result is out and the
  // pipeline has had time to finish bytes that cause none.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (points_pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_limits(input logic [2:0] panel, input logic [2:0] client);
    drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= trpd_pkg::REG_PANEL_LIMIT;
    cfg_wdata <= panel;
    @(negedge clk);
    cfg_index <= trpd_pkg::REG_CLIENT_CAP;
    cfg_wdata <= client;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_panel  = panel;
    cur_client = client;
  endtask

  // One read: mostly a flag byte and a report that runs to or just past its final
  // point, sometimes cut short, overlong, unsettled or plain noise.
  task automatic send_read;
    int         kind;
    int         len;
    int         k;
    int         i;
    logic [3:0] count;
    logic [3:0] upper;
    logic [7:0] first;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
      return;
    end
    count = (kind < 15) ? 4'($urandom_range(1, 5)) : 4'($urandom_range(0, 15));
    upper = 4'($urandom_range(0, 15));
    send_word(trpd_pkg::OP_FLAG, {upper, count});
    if (count == 4'd0 && $urandom_range(0, 3) != 0) return;
    upper = 4'($urandom_range(0, 15));
    first = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                        : {upper, trpd_pkg::POINT_ID};
    send_word(trpd_pkg::OP_REPORT, first);
    // Bytes needed to reach the final point under the current limits.
    k = int'(count);
    if (k > int'(cur_panel)) k = int'(cur_panel);
    if (k > int'(cur_client)) k = int'(cur_client);
    if (k > trpd_pkg::NUM_POINTS) k = trpd_pkg::NUM_POINTS;
    len = (k == 0) ? 0 : ((k == 1) ? 3 : (k - 1) * 5 + 5);
    case ($urandom_range(0, 5))
      0:       len = $urandom_range(0, 26);
      1:       len = $urandom_range(26, 30);
      default: len = len + $urandom_range(0, 2);
    endcase
    for (i = 0; i < len; i++) send_word(trpd_pkg::OP_REPORT, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int p;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_word     = '0;
    cfg_wr_en   = 1'b0;
    cfg_index   = trpd_pkg::REG_PANEL_LIMIT;
    cfg_wdata   = '0;
    steady_tail = 1'b0;
    bytes_sent  = 0;
    cur_panel   = trpd_pkg::LIMIT_RESET;
    cur_client  = trpd_pkg::LIMIT_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Report byte with no read open is ignored.
    send_word(trpd_pkg::OP_REPORT, 8'hAA);
    // Zero touch count: one empty word.
    send_word(trpd_pkg::OP_FLAG, 8'hF0);
    // Bad identifier: unsettled report, then a stray byte that is ignored.
    send_word(trpd_pkg::OP_FLAG, 8'h01);
    send_word(trpd_pkg::OP_REPORT, 8'h05);
    send_word(trpd_pkg::OP_REPORT, 8'h33);
    // Two points at the coordinate extremes, with filler between records.
    send_word(trpd_pkg::OP_FLAG, 8'h02);
    send_word(trpd_pkg::OP_REPORT, 8'hF6);
    send_word(trpd_pkg::OP_REPORT, 8'hFF);
    send_word(trpd_pkg::OP_REPORT, 8'h00);
    send_word(trpd_pkg::OP_REPORT, 8'hF0);
    repeat (4) send_word(trpd_pkg::OP_REPORT, 8'h5A);
    send_word(trpd_pkg::OP_REPORT, 8'h00);
    send_word(trpd_pkg::OP_REPORT, 8'hFF);
    send_word(trpd_pkg::OP_REPORT, 8'h0F);
    // New flag byte in the middle of a report abandons it.
    send_word(trpd_pkg::OP_FLAG, 8'h05);
    send_word(trpd_pkg::OP_REPORT, 8'h06);
    send_word(trpd_pkg::OP_REPORT, 8'h12);
    send_word(trpd_pkg::OP_FLAG, 8'h00);

    // Random reads under each limit setting; the sender drains between phases.
    for (p = 0; p < NUM_PHASES; p++) begin
      set_limits(phase_panel[p], phase_client[p]);
      if (p == NUM_PHASES - 1) steady_tail = 1'b1;
      while (bytes_sent < (ITEM_TARGET * (p + 1)) / NUM_PHASES) send_read();
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/trpd_pkg.sv
rtl/core/trpd_in_stage.sv
rtl/core/trpd_parser.sv
rtl/core/touch_report_point_decoder.sv
rtl/core/trpd_checker.sv
tb/sv/touch_point_checker.sv
tb/sv/tb_touch_report_point_decoder.sv
